FILE: rtl/mandelbrot_pixel_colorizer_assert.svh
// assertion macros for the mandelbrot pixel colorizer
`ifndef MANDELBROT_PIXEL_COLORIZER_ASSERT_SVH
`define MANDELBROT_PIXEL_COLORIZER_ASSERT_SVH

// same-cycle implication
`define MPC_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mpc assertion failed");

// next-cycle implication
`define MPC_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mpc assertion failed");

`endif

FILE: rtl/mpc_pkg.sv
// shared types, constants and functions of the mandelbrot pixel colorizer
`timescale 1ns / 1ps

package mpc_pkg;

	localparam int WIDTH       = 1000;
	localparam int HEIGHT      = 600;
	localparam int FRAC_BITS   = 28;
	// 2*pixel - size for sizes up to 4096
	localparam int D_W         = 14;
	localparam int PROD_W      = D_W + 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int ADDR_W      = 4;

	localparam logic [30:0]        ZOOM_RST     = 31'd1073742;
	localparam logic signed [31:0] OFFSET_X_RST = -32'sd187904819;
	localparam logic signed [31:0] OFFSET_Y_RST = 32'sd0;
	localparam logic [7:0]         MAX_ITER_RST = 8'd127;

	localparam logic [1:0] REG_ZOOM     = 2'd0;
	localparam logic [1:0] REG_OFFSET_X = 2'd1;
	localparam logic [1:0] REG_OFFSET_Y = 2'd2;
	localparam logic [1:0] REG_MAX_ITER = 2'd3;

	// escape bound |z|^2 > 4 in double-width fraction
	localparam logic [63:0] LIMIT = 64'd4 << (2 * FRAC_BITS);

	typedef struct packed {
		logic signed [31:0] cr;
		logic signed [31:0] ci;
	} coord_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// four-band palette, black inside the set
	function automatic rgb_t palette(input logic in_set, input logic [7:0] n);
		rgb_t c;
		logic [7:0] d8;
		logic [11:0] t;
		c = '0;
		d8 = '0;
		t = '0;
		if (!in_set) begin
			if (n == 8'd0) begin
				c.red = 8'd255;
			end else if (n inside {[8'd1:8'd15]}) begin
				d8 = 8'd16 - n;
				c.red = {d8[3:0], 4'b0000};
				c.blue = {n[3:0], 4'b0000} - 8'd1;
			end else if (n inside {[8'd16:8'd31]}) begin
				c.green = {n[3:0], 4'b0000};
				d8 = 8'd32 - n;
				t = {d8, 4'b0000} - 12'd1;
				c.blue = t[7:0];
			end else if (n inside {[8'd32:8'd63]}) begin
				c.red = {n[4:0], 3'b000};
				d8 = 8'd64 - n;
				t = {1'b0, d8, 3'b000} - 12'd1;
				c.green = t[7:0];
			end else if (n inside {[8'd64:8'd127]}) begin
				c.red = 8'd255 - {n[5:0], 2'b00};
			end else begin
				c.red = 8'd0;
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/mpc_front.sv
// front end: maps a pixel to the point c and pushes it into the queue
`timescale 1ns / 1ps

module mpc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [9:0]           pixel_x,
	input  logic [9:0]           pixel_y,
	input  logic [30:0]          zoom,
	input  logic signed [31:0]   offset_x,
	input  logic signed [31:0]   offset_y,
	input  logic                 full,
	output logic                 push,
	output mpc_pkg::coord_t      coord
);

	localparam int D_W    = mpc_pkg::D_W;
	localparam int PROD_W = mpc_pkg::PROD_W;

	logic signed [D_W-1:0]    d2x, d2y;
	logic signed [31:0]       zoom_s;
	logic signed [PROD_W-1:0] prod_x_s1, prod_y_s1;
	logic                     v_s1;
	logic signed [PROD_W:0]   sum_x, sum_y;
	logic                     accept;

	// twice the distance from the image center, keeps half pixels exact
	assign d2x = $signed(D_W'({pixel_x, 1'b0})) - $signed(D_W'(mpc_pkg::WIDTH));
	assign d2y = $signed(D_W'({pixel_y, 1'b0})) - $signed(D_W'(mpc_pkg::HEIGHT));
	assign zoom_s = $signed({1'b0, zoom});

	assign push   = v_s1 && !full;
	assign busy   = v_s1 && full;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_x_s1 <= d2x * zoom_s;
			prod_y_s1 <= d2y * zoom_s;
		end
	end

	// halve with floor, add center, saturate
	assign sum_x = (PROD_W+1)'(prod_x_s1 >>> 1) + (PROD_W+1)'(offset_x);
	assign sum_y = (PROD_W+1)'(prod_y_s1 >>> 1) + (PROD_W+1)'(offset_y);

	assign coord.cr = mpc_pkg::sat32(64'(sum_x));
	assign coord.ci = mpc_pkg::sat32(64'(sum_y));

endmodule

FILE: rtl/mpc_queue.sv
// small queue of mapped points between front and back end
`timescale 1ns / 1ps

module mpc_queue #(
	parameter int DEPTH = mpc_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mpc_pkg::coord_t din,
	output logic            full,
	input  logic            pop,
	output mpc_pkg::coord_t dout,
	output logic            empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mpc_pkg::coord_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= din;
	end

endmodule

FILE: rtl/mpc_back.sv
// back end: escape-time iteration and palette lookup
`timescale 1ns / 1ps

module mpc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  mpc_pkg::coord_t head,
	output logic            pop,
	input  logic [7:0]      max_iter,
	output logic            done,
	output logic            in_set,
	output logic [7:0]      iter_count,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue
);

	localparam int F = mpc_pkg::FRAC_BITS;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MUL   = 4'b0010,
		ST_STEP  = 4'b0100,
		ST_COLOR = 4'b1000
	} bstate_t;

	bstate_t            state_q;
	logic signed [31:0] cr_q, ci_q, zr_q, zi_q;
	logic signed [63:0] rr_q, ii_q, ri_q;
	logic [8:0]         n_q;
	logic               res_set_q;
	logic [7:0]         res_cnt_q;
	logic               done_q;
	logic               in_set_q;
	logic [7:0]         iter_count_q;
	mpc_pkg::rgb_t      rgb_q;

	logic [63:0]        mag;
	logic               escape;
	logic signed [63:0] diff;
	logic signed [31:0] nr, ni;
	mpc_pkg::rgb_t      rgb;

	assign pop = (state_q == ST_IDLE) && !empty;

	assign mag    = $unsigned(rr_q) + $unsigned(ii_q);
	assign escape = (mag > mpc_pkg::LIMIT) || (n_q > {1'b0, max_iter});
	assign diff   = rr_q - ii_q;
	// zr*zi shifted one less gives the doubled cross term
	assign nr     = mpc_pkg::sat32((diff >>> F) + 64'(cr_q));
	assign ni     = mpc_pkg::sat32((ri_q >>> (F - 1)) + 64'(ci_q));
	assign rgb    = mpc_pkg::palette(res_set_q, res_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!empty)
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (escape || (nr == cr_q && ni == ci_q))
						state_q <= ST_COLOR;
					else
						state_q <= ST_MUL;
				end
				ST_COLOR: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cr_q <= head.cr;
				ci_q <= head.ci;
				zr_q <= head.cr;
				zi_q <= head.ci;
				n_q  <= '0;
			end
			ST_MUL: begin
				rr_q <= zr_q * zr_q;
				ii_q <= zi_q * zi_q;
				ri_q <= zr_q * zi_q;
			end
			ST_STEP: begin
				if (escape) begin
					res_set_q <= (n_q >= {1'b0, max_iter});
					res_cnt_q <= (n_q >= {1'b0, max_iter}) ? 8'd0 : n_q[7:0];
				end else if (nr == cr_q && ni == ci_q) begin
					// orbit came back exactly to c
					res_set_q <= 1'b1;
					res_cnt_q <= 8'd0;
				end else begin
					zr_q <= nr;
					zi_q <= ni;
					n_q  <= n_q + 1'b1;
				end
			end
			ST_COLOR: begin
				in_set_q     <= res_set_q;
				iter_count_q <= res_cnt_q;
				rgb_q        <= rgb;
			end
			default: begin
			end
		endcase
	end

	assign done       = done_q;
	assign in_set     = in_set_q;
	assign iter_count = iter_count_q;
	assign red        = rgb_q.red;
	assign green      = rgb_q.green;
	assign blue       = rgb_q.blue;

endmodule

FILE: rtl/mandelbrot_pixel_colorizer.sv
// top level of the mandelbrot pixel colorizer: register port, front, queue, back
`timescale 1ns / 1ps

// A pixel is taken when start is high and busy is low; busy only rises when the
// front end holds a mapped point and the queue in front of the iterator is full.
// The front end registers its products, so pixels can be handed over back to back
// until the queue fills. For each pixel the iterator runs n steps of z = z^2 + c,
// n being at most max_iter + 1: each step passes a multiply state on three 32x32
// multipliers and then a state of saturating update and escape test.
// Results appear in pixel order; done is high for exactly one cycle per pixel and
// the result must be taken in that cycle. Registers are to be written over the APB
// port only while no pixel is in flight; the user is bound to this, the block does
// not enforce it.
module mandelbrot_pixel_colorizer #(
	parameter int QUEUE_DEPTH = mpc_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mpc_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  logic [9:0]                  pixel_x,
	input  logic [9:0]                  pixel_y,
	output logic                        done,
	output logic                        in_set,
	output logic [7:0]                  iter_count,
	output logic [7:0]                  red,
	output logic [7:0]                  green,
	output logic [7:0]                  blue
);

	logic [30:0]        zoom_q;
	logic signed [31:0] offset_x_q;
	logic signed [31:0] offset_y_q;
	logic [7:0]         max_iter_q;
	logic               wr_en;
	logic [1:0]         reg_idx;

	logic               push, full, pop, empty;
	mpc_pkg::coord_t    coord, head;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_q     <= mpc_pkg::ZOOM_RST;
			offset_x_q <= mpc_pkg::OFFSET_X_RST;
			offset_y_q <= mpc_pkg::OFFSET_Y_RST;
			max_iter_q <= mpc_pkg::MAX_ITER_RST;
		end else if (wr_en) begin
			case (reg_idx)
				mpc_pkg::REG_ZOOM:     zoom_q     <= pwdata[30:0];
				mpc_pkg::REG_OFFSET_X: offset_x_q <= pwdata;
				mpc_pkg::REG_OFFSET_Y: offset_y_q <= pwdata;
				mpc_pkg::REG_MAX_ITER: max_iter_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mpc_pkg::REG_ZOOM:     prdata = {1'b0, zoom_q};
			mpc_pkg::REG_OFFSET_X: prdata = offset_x_q;
			mpc_pkg::REG_OFFSET_Y: prdata = offset_y_q;
			mpc_pkg::REG_MAX_ITER: prdata = {24'd0, max_iter_q};
			default:               prdata = '0;
		endcase
	end

	mpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.zoom     (zoom_q),
		.offset_x (offset_x_q),
		.offset_y (offset_y_q),
		.full     (full),
		.push     (push),
		.coord    (coord)
	);

	mpc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (coord),
		.full   (full),
		.pop    (pop),
		.dout   (head),
		.empty  (empty)
	);

	mpc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.head       (head),
		.pop        (pop),
		.max_iter   (max_iter_q),
		.done       (done),
		.in_set     (in_set),
		.iter_count (iter_count),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

`include "mandelbrot_pixel_colorizer_assert.svh"

	// a result transaction lasts exactly one cycle
	`MPC_ASSERT_NXT(a_done_single, clk, arst_n, done, !done)
	`MPC_ASSERT_IMP(a_set_black, clk, arst_n, done && in_set, {iter_count, red, green, blue} == '0)
	// an escaped point always stays below the limit
	`MPC_ASSERT_IMP(a_count_bound, clk, arst_n, done && !in_set, iter_count < max_iter_q)

endmodule

FILE: dv/mandelbrot_pixel_colorizer_test.sv
// testbench of the mandelbrot pixel colorizer: directed and random pixels checked against a predictor
`timescale 1ns / 1ps

module mandelbrot_pixel_colorizer_test;

	localparam int IMG_W = 1000;
	localparam int IMG_H = 600;
	localparam int FRAC = 28;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;
	localparam longint unsigned ESCAPE_BOUND = 64'd4 << (2 * FRAC);
	localparam int RANDOM_PHASES = 14;
	localparam int PIXELS_PER_PHASE = 88;

	typedef struct {
		logic [9:0] px;
		logic [9:0] py;
		logic       in_set;
		logic [7:0] count;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} shade_t;

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [mpc_pkg::ADDR_W-1:0] paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       start;
	logic                       busy;
	logic [9:0]                 pixel_x;
	logic [9:0]                 pixel_y;
	logic                       done;
	logic                       in_set;
	logic [7:0]                 iter_count;
	logic [7:0]                 red;
	logic [7:0]                 green;
	logic [7:0]                 blue;

	// register image kept by the predictor
	logic [30:0]        cfg_zoom = 31'd1073742;
	logic signed [31:0] cfg_off_x = -32'sd187904819;
	logic signed [31:0] cfg_off_y = 32'sd0;
	logic [7:0]         cfg_max_iter = 8'd127;

	shade_t pending_shades[$];
	bit     steady;
	int     mismatches;
	int     pixels_sent;
	int     shades_checked;
	int     inside_seen;
	int     escaped_seen;
	int     settings_used;

	mandelbrot_pixel_colorizer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.done(done),
		.in_set(in_set),
		.iter_count(iter_count),
		.red(red),
		.green(green),
		.blue(blue)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic longint clamp32(input longint v);
		if (v > Q_MAX)
			return Q_MAX;
		if (v < Q_MIN)
			return Q_MIN;
		return v;
	endfunction

	// floor((2p - size) * zoom / 2) + centre, saturated
	function automatic longint map_to_plane(input int pix, input int span,
			input logic signed [31:0] centre);
		longint d2;
		longint step;
		d2 = 2 * pix - span;
		step = cfg_zoom;
		return clamp32(((d2 * step) >>> 1) + longint'(centre));
	endfunction

	// -1 when the point counts as inside the set
	function automatic int escape_steps(input longint cr, input longint ci);
		longint zr, zi, rr, ii, nr, ni;
		longint unsigned mag;
		int n;
		zr = cr;
		zi = ci;
		n = 0;
		forever begin
			rr = zr * zr;
			ii = zi * zi;
			mag = rr + ii;
			if (mag > ESCAPE_BOUND || n > cfg_max_iter)
				break;
			nr = clamp32(((rr - ii) >>> FRAC) + cr);
			ni = clamp32(((zr * zi) >>> (FRAC - 1)) + ci);
			zr = nr;
			zi = ni;
			if (zr == cr && zi == ci)
				return -1;
			n++;
		end
		return (n >= cfg_max_iter) ? -1 : n;
	endfunction

	function automatic shade_t predict_shade(input logic [9:0] x, input logic [9:0] y);
		shade_t s;
		int n, r, g, b;
		n = escape_steps(map_to_plane(int'(x), IMG_W, cfg_off_x),
			map_to_plane(int'(y), IMG_H, cfg_off_y));
		r = 0;
		g = 0;
		b = 0;
		if (n == 0) begin
			r = 255;
		end else if (n > 0 && n < 16) begin
			r = 16 * (16 - n);
			b = 16 * n - 1;
		end else if (n >= 16 && n < 32) begin
			g = 16 * (n - 16);
			b = 16 * (32 - n) - 1;
		end else if (n >= 32 && n < 64) begin
			r = 8 * (n - 32);
			g = 8 * (64 - n) - 1;
		end else if (n >= 64) begin
			r = 255 - 4 * (n - 64);
			if (r < 0)
				r = 0;
		end
		s.px = x;
		s.py = y;
		s.in_set = (n < 0);
		s.count = (n < 0) ? 8'd0 : 8'(n);
		s.red = 8'(r);
		s.green = 8'(g);
		s.blue = 8'(b);
		return s;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", msg);
	endtask

	// one apb transaction, setup then access
	task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(input logic [1:0] idx);
		logic [31:0] rd, want, mask;
		case (idx)
			mpc_pkg::REG_ZOOM: begin
				want = {1'b0, cfg_zoom};
				mask = 32'h7fffffff;
			end
			mpc_pkg::REG_OFFSET_X: begin
				want = cfg_off_x;
				mask = 32'hffffffff;
			end
			mpc_pkg::REG_OFFSET_Y: begin
				want = cfg_off_y;
				mask = 32'hffffffff;
			end
			default: begin
				want = {24'd0, cfg_max_iter};
				mask = 32'h000000ff;
			end
		endcase
		apb_xfer(1'b0, idx, 32'd0, rd);
		if ((rd & mask) !== (want & mask))
			note_mismatch($sformatf("register %0d read 0x%08h, expected 0x%08h",
				idx, rd & mask, want & mask));
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] rd;
		case (idx)
			mpc_pkg::REG_ZOOM:     cfg_zoom = value[30:0];
			mpc_pkg::REG_OFFSET_X: cfg_off_x = value;
			mpc_pkg::REG_OFFSET_Y: cfg_off_y = value;
			default:               cfg_max_iter = value[7:0];
		endcase
		apb_xfer(1'b1, idx, value, rd);
		check_reg(idx);
	endtask

	task automatic set_window(input logic [30:0] z, input logic [31:0] ox, input logic [31:0] oy,
			input logic [7:0] mi);
		write_reg(mpc_pkg::REG_ZOOM, {1'b0, z});
		write_reg(mpc_pkg::REG_OFFSET_X, ox);
		write_reg(mpc_pkg::REG_OFFSET_Y, oy);
		write_reg(mpc_pkg::REG_MAX_ITER, {24'd0, mi});
		settings_used++;
	endtask

	task automatic push_pixel(input logic [9:0] x, input logic [9:0] y);
		int gap;
		start <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		do @(posedge clk); while (busy !== 1'b0);
		pending_shades.push_back(predict_shade(x, y));
		pixels_sent++;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// sender holds off until every pixel in flight has come back
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_shades.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_reset_window();
		check_reg(mpc_pkg::REG_ZOOM);
		check_reg(mpc_pkg::REG_OFFSET_X);
		check_reg(mpc_pkg::REG_OFFSET_Y);
		check_reg(mpc_pkg::REG_MAX_ITER);
		push_pixel(10'd0, 10'd0);
		push_pixel(10'd999, 10'd599);
		push_pixel(10'd500, 10'd300);
		push_pixel(10'd250, 10'd150);
		// pixels past the image edge go through the same mapping
		push_pixel(10'd1023, 10'd1023);
		push_pixel(10'd1023, 10'd0);
		push_pixel(10'd0, 10'd1023);
		wait_idle();
	endtask

	task automatic test_zero_zoom();
		// every pixel lands on c = 1, which escapes after two steps
		set_window(31'd0, 32'h10000000, 32'd0, 8'd20);
		push_pixel(10'd0, 10'd0);
		push_pixel(10'd1023, 10'd1023);
		wait_idle();
	endtask

	task automatic test_zero_max_iter();
		set_window(31'd1073742, -32'sd187904819, 32'd0, 8'd0);
		push_pixel(10'd0, 10'd0);
		push_pixel(10'd999, 10'd599);
		wait_idle();
	endtask

	task automatic test_saturation();
		set_window(31'h7fffffff, 32'h7fffffff, 32'h80000000, 8'd255);
		push_pixel(10'd0, 10'd0);
		push_pixel(10'd1023, 10'd1023);
		push_pixel(10'd500, 10'd300);
		wait_idle();
	endtask

	task automatic test_cycle_back();
		// c = 0 is a fixed point, c = -1 returns to itself after two steps
		set_window(31'd1073742, 32'd0, 32'd0, 8'd127);
		push_pixel(10'd500, 10'd300);
		wait_idle();
		write_reg(mpc_pkg::REG_OFFSET_X, 32'hf0000000);
		push_pixel(10'd500, 10'd300);
		wait_idle();
	endtask

	task automatic test_iteration_limit();
		set_window(31'd1073742, -32'sd187904819, 32'd0, 8'd255);
		push_pixel(10'd500, 10'd300);
		push_pixel(10'd300, 10'd300);
		push_pixel(10'd700, 10'd100);
		wait_idle();
	endtask

	task automatic test_random_windows();
		logic [30:0] z;
		logic [31:0] ox, oy;
		logic [7:0]  mi;
		logic [9:0]  x, y;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			z = 31'($urandom() >> (($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) :
				$urandom_range(10, 16)));
			if (z == 31'd0)
				z = 31'd1;
			ox = ($urandom_range(0, 9) == 0) ? $urandom() :
				$urandom_range(0, 671088640) - 32'd536870912;
			oy = ($urandom_range(0, 9) == 0) ? $urandom() :
				$urandom_range(0, 644245094) - 32'd322122547;
			mi = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) :
				8'($urandom_range(1, 64));
			case (p)
				0: mi = 8'd255;
				1: mi = 8'd1;
				2: begin
					z = 31'h7fffffff;
					ox = 32'h80000000;
					oy = 32'h7fffffff;
				end
				3: z = 31'd1;
				default: ;
			endcase
			set_window(z, ox, oy, mi);
			steady = (p % 4 == 1);
			for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
				x = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(1000, 1023)) :
					10'($urandom_range(0, 999));
				y = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(600, 1023)) :
					10'($urandom_range(0, 599));
				push_pixel(x, y);
			end
			wait_idle();
		end
		steady = 1'b0;
	endtask

	// result checker: each done pulse marks one result, which cannot be held off
	initial begin
		shade_t want;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && done === 1'b1) begin
				if (pending_shades.size() == 0) begin
					note_mismatch($sformatf("unexpected result in_set=%0b count=%0d",
						in_set, iter_count));
				end else begin
					want = pending_shades.pop_front();
					shades_checked++;
					if (want.in_set)
						inside_seen++;
					else
						escaped_seen++;
					if (in_set !== want.in_set || iter_count !== want.count ||
							red !== want.red || green !== want.green || blue !== want.blue)
						note_mismatch($sformatf({"pixel (%0d,%0d) expected in_set=%0b count=%0d ",
							"rgb=%0d,%0d,%0d got in_set=%0b count=%0d rgb=%0d,%0d,%0d"},
							want.px, want.py, want.in_set, want.count, want.red, want.green,
							want.blue, in_set, iter_count, red, green, blue));
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		start <= 1'b0;
		pixel_x <= '0;
		pixel_y <= '0;
		steady = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window();
		test_zero_zoom();
		test_zero_max_iter();
		test_saturation();
		test_cycle_back();
		test_iteration_limit();
		test_random_windows();

		start <= 1'b0;
		while (pending_shades.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d pixels sent under %0d window settings, %0d results compared",
			pixels_sent, settings_used + 1, shades_checked);
		$display("%0d inside the set, %0d escaped, %0d mismatches",
			inside_seen, escaped_seen, mismatches);
		if (mismatches == 0 && pending_shades.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
